// ===== rtl/i2c_master_register_block_core_defines.svh =====
// Assertion macros shared by the I2C controller register block RTL.
`ifndef I2C_MASTER_REGISTER_BLOCK_CORE_DEFINES_SVH
`define I2C_MASTER_REGISTER_BLOCK_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted.
`define I2CM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("i2cm: assertion failed");
// Clocked check that also holds during reset.
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("i2cm: reset assertion failed");
`else
`define I2CM_ASSERT(lbl, clk, rstn, prop)
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C controller register block.
package i2cm_pkg;

    // Receive FIFO default depth
    localparam int RX_DEPTH_DEF = 16;

    // Access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Register word offsets
    localparam logic [5:0] W_CON           = 6'd0;
    localparam logic [5:0] W_TAR           = 6'd1;
    localparam logic [5:0] W_SAR           = 6'd2;
    localparam logic [5:0] W_XFER_CMD      = 6'd4;
    localparam logic [5:0] W_SS_HCNT       = 6'd5;
    localparam logic [5:0] W_SS_LCNT       = 6'd6;
    localparam logic [5:0] W_FS_HCNT       = 6'd7;
    localparam logic [5:0] W_FS_LCNT       = 6'd8;
    localparam logic [5:0] W_INTR_STAT     = 6'd11;
    localparam logic [5:0] W_INTR_MASK     = 6'd12;
    localparam logic [5:0] W_RAW_STAT      = 6'd13;
    localparam logic [5:0] W_RX_TL         = 6'd14;
    localparam logic [5:0] W_TX_TL         = 6'd15;
    localparam logic [5:0] W_CLR_INTR      = 6'd16;
    localparam logic [5:0] W_CLR_RX_UNDER  = 6'd17;
    localparam logic [5:0] W_CLR_RX_OVER   = 6'd18;
    localparam logic [5:0] W_CLR_TX_OVER   = 6'd19;
    localparam logic [5:0] W_CLR_TX_ABRT   = 6'd21;
    localparam logic [5:0] W_CLR_STOP_DET  = 6'd24;
    localparam logic [5:0] W_CLR_START_DET = 6'd25;
    localparam logic [5:0] W_ENABLE        = 6'd27;
    localparam logic [5:0] W_STATUS        = 6'd28;
    localparam logic [5:0] W_TXFLR         = 6'd29;
    localparam logic [5:0] W_RXFLR         = 6'd30;
    localparam logic [5:0] W_HOLD_TIME     = 6'd31;
    localparam logic [5:0] W_ABRT_SRC      = 6'd32;
    localparam logic [5:0] W_DMA_CR        = 6'd34;
    localparam logic [5:0] W_DMA_TDLR      = 6'd35;
    localparam logic [5:0] W_DMA_RDLR      = 6'd36;
    localparam logic [5:0] W_SPKLEN        = 6'd40;
    localparam logic [5:0] W_CLR_RESTART   = 6'd42;
    localparam logic [5:0] W_PARAM1        = 6'd61;
    localparam logic [5:0] W_VERSION       = 6'd62;
    localparam logic [5:0] W_TYPE          = 6'd63;

    // Interrupt status bits
    localparam logic [11:0] INT_RX_UNDER  = 12'h001;
    localparam logic [11:0] INT_RX_OVER   = 12'h002;
    localparam logic [11:0] INT_RX_FULL   = 12'h004;
    localparam logic [11:0] INT_TX_OVER   = 12'h008;
    localparam logic [11:0] INT_TX_IDLE   = 12'h010;
    localparam logic [11:0] INT_TX_ABRT   = 12'h040;
    localparam logic [11:0] INT_STOP_DET  = 12'h200;
    localparam logic [11:0] INT_START_DET = 12'h400;

    // Transfer command bit positions
    localparam int CMD_READ_BIT    = 8;
    localparam int CMD_STOP_BIT    = 9;
    localparam int CMD_RESTART_BIT = 10;

    // Identification words
    localparam logic [31:0] ID_PARAM1  = 32'h00FF_FF6E;
    localparam logic [31:0] ID_VERSION = 32'h3230_312A;
    localparam logic [31:0] ID_TYPE    = 32'h4457_0140;

    // Reset values
    localparam logic [6:0]  RST_CON     = 7'h7F;
    localparam logic [9:0]  RST_TAR     = 10'h055;
    localparam logic [9:0]  RST_SAR     = 10'h055;
    localparam logic [15:0] RST_SS_HCNT = 16'h0028;
    localparam logic [15:0] RST_SS_LCNT = 16'h002F;
    localparam logic [15:0] RST_FS_HCNT = 16'h0006;
    localparam logic [15:0] RST_FS_LCNT = 16'h000D;
    localparam logic [15:0] RST_HOLD_TIME = 16'h0001;
    localparam logic [7:0]  RST_SPKLEN  = 8'h07;

    // Byte pushed when no device answers a read
    localparam logic [7:0] NO_DEVICE_BYTE = 8'hFF;

    // One register access beat
    typedef struct packed {
        logic        func;
        logic [5:0]  reg_word;
        logic [31:0] write_data;
        logic        device_present;
        logic [7:0]  device_byte;
    } req_t;

    // One result beat
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_pulse;
        logic [6:0]  target_addr;
        logic        bus_restart;
        logic        bus_write;
        logic [7:0]  bus_write_byte;
        logic        bus_read;
        logic        bus_stop;
    } result_t;

endpackage

// ===== rtl/i2cm_ram.sv =====
// Generic single write port RAM with registered read.
module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/i2cm_regs.sv =====
// Register file, interrupt status and receive FIFO pointers.
`include "i2c_master_register_block_core_defines.svh"

module i2cm_regs #(
    parameter int RX_DEPTH = i2cm_pkg::RX_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  i2cm_pkg::req_t              req,
    output i2cm_pkg::result_t           res,
    output logic                        use_ram,
    output logic                        ram_wr_en,
    output logic [$clog2(RX_DEPTH)-1:0] ram_wr_addr,
    output logic [7:0]                  ram_wr_data,
    output logic                        ram_rd_en,
    output logic [$clog2(RX_DEPTH)-1:0] ram_rd_addr
);

    localparam int PTR_W = $clog2(RX_DEPTH);
    localparam int LVL_W = $clog2(RX_DEPTH + 1);
    localparam int CMP_W = (LVL_W > 8) ? LVL_W : 8;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(RX_DEPTH);

    logic [6:0]       con_reg, con_next;
    logic [9:0]       tar_reg, tar_next;
    logic [9:0]       sar_reg, sar_next;
    logic [15:0]      ss_hcnt_reg, ss_hcnt_next;
    logic [15:0]      ss_lcnt_reg, ss_lcnt_next;
    logic [15:0]      fs_hcnt_reg, fs_hcnt_next;
    logic [15:0]      fs_lcnt_reg, fs_lcnt_next;
    logic [11:0]      mask_reg, mask_next;
    logic [11:0]      raw_reg, raw_next;
    logic [7:0]       rx_tl_reg, rx_tl_next;
    logic [7:0]       tx_tl_reg, tx_tl_next;
    logic [1:0]       enable_reg, enable_next;
    logic [15:0]      hold_time_reg, hold_time_next;
    logic [1:0]       dma_cr_reg, dma_cr_next;
    logic [4:0]       dma_tdlr_reg, dma_tdlr_next;
    logic [4:0]       dma_rdlr_reg, dma_rdlr_next;
    logic [7:0]       spklen_reg, spklen_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    logic             is_write;
    logic             do_update;
    logic             fifo_empty;
    logic             fifo_full;
    logic [11:0]      raw_mod;
    logic [11:0]      raw_upd;
    logic [31:0]      status_word;

    assign is_write   = (req.func == i2cm_pkg::FUNC_WRITE);
    assign fifo_empty = (level_reg == '0);
    assign fifo_full  = (level_reg == LVL_FULL);
    assign ram_rd_addr = rd_ptr_reg;
    assign ram_wr_addr = wr_ptr_reg;

    // STATUS word: TFNF/TFE always set, activity clear, RX not empty, RX full
    always_comb begin
        status_word = 32'h0000_0006;
        status_word[3] = !fifo_empty;
        status_word[4] = fifo_full;
    end

    // Access decode and state update
    always_comb begin
        con_next      = con_reg;
        tar_next      = tar_reg;
        sar_next      = sar_reg;
        ss_hcnt_next  = ss_hcnt_reg;
        ss_lcnt_next  = ss_lcnt_reg;
        fs_hcnt_next  = fs_hcnt_reg;
        fs_lcnt_next  = fs_lcnt_reg;
        mask_next     = mask_reg;
        rx_tl_next    = rx_tl_reg;
        tx_tl_next    = tx_tl_reg;
        enable_next   = enable_reg;
        hold_time_next = hold_time_reg;
        dma_cr_next   = dma_cr_reg;
        dma_tdlr_next = dma_tdlr_reg;
        dma_rdlr_next = dma_rdlr_reg;
        spklen_next   = spklen_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        level_next    = level_reg;
        raw_mod       = raw_reg;
        ram_wr_en     = 1'b0;
        ram_wr_data   = req.device_present ? req.device_byte : i2cm_pkg::NO_DEVICE_BYTE;
        ram_rd_en     = 1'b0;
        use_ram       = 1'b0;
        do_update     = 1'b0;
        res           = '0;

        if (is_write) begin
            do_update = 1'b1;
            case (req.reg_word)
                i2cm_pkg::W_CON:       con_next = req.write_data[6:0];
                i2cm_pkg::W_TAR:       tar_next = req.write_data[9:0];
                i2cm_pkg::W_SAR:       sar_next = req.write_data[9:0];
                i2cm_pkg::W_XFER_CMD: begin
                    res.target_addr = tar_reg[6:0];
                    res.bus_restart = req.write_data[i2cm_pkg::CMD_RESTART_BIT]
                                      && req.device_present;
                    if (req.write_data[i2cm_pkg::CMD_READ_BIT]) begin
                        res.bus_read = req.device_present;
                        // push into the receive FIFO, drop on overflow
                        if (fifo_full) begin
                            raw_mod = raw_mod | i2cm_pkg::INT_RX_OVER;
                        end else begin
                            ram_wr_en   = 1'b1;
                            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0
                                                                   : wr_ptr_reg + 1'b1;
                            level_next  = level_reg + 1'b1;
                        end
                    end else if (req.device_present) begin
                        res.bus_write      = 1'b1;
                        res.bus_write_byte = req.write_data[7:0];
                    end
                    if (req.write_data[i2cm_pkg::CMD_STOP_BIT]) begin
                        raw_mod      = raw_mod | i2cm_pkg::INT_STOP_DET;
                        res.bus_stop = req.device_present;
                    end
                end
                i2cm_pkg::W_SS_HCNT:     ss_hcnt_next  = req.write_data[15:0];
                i2cm_pkg::W_SS_LCNT:     ss_lcnt_next  = req.write_data[15:0];
                i2cm_pkg::W_FS_HCNT:     fs_hcnt_next  = req.write_data[15:0];
                i2cm_pkg::W_FS_LCNT:     fs_lcnt_next  = req.write_data[15:0];
                i2cm_pkg::W_INTR_MASK:   mask_next     = req.write_data[11:0];
                i2cm_pkg::W_RX_TL:       rx_tl_next    = req.write_data[7:0];
                i2cm_pkg::W_TX_TL:       tx_tl_next    = req.write_data[7:0];
                i2cm_pkg::W_CLR_INTR:    raw_mod       = '0;
                i2cm_pkg::W_CLR_TX_ABRT: raw_mod       = raw_mod & ~i2cm_pkg::INT_TX_ABRT;
                i2cm_pkg::W_ENABLE:      enable_next   = req.write_data[1:0];
                i2cm_pkg::W_HOLD_TIME:   hold_time_next = req.write_data[15:0];
                i2cm_pkg::W_DMA_CR:      dma_cr_next   = req.write_data[1:0];
                i2cm_pkg::W_DMA_TDLR:    dma_tdlr_next = req.write_data[4:0];
                i2cm_pkg::W_DMA_RDLR:    dma_rdlr_next = req.write_data[4:0];
                i2cm_pkg::W_SPKLEN:      spklen_next   = req.write_data[7:0];
                default: ;
            endcase
        end else begin
            case (req.reg_word)
                i2cm_pkg::W_CON:       res.read_data = 32'(con_reg);
                i2cm_pkg::W_TAR:       res.read_data = 32'(tar_reg);
                i2cm_pkg::W_SAR:       res.read_data = 32'(sar_reg);
                i2cm_pkg::W_XFER_CMD: begin
                    do_update = 1'b1;
                    // pop: data arrives from the registered RAM read in the next cycle
                    if (fifo_empty) begin
                        raw_mod = raw_mod | i2cm_pkg::INT_RX_UNDER;
                    end else begin
                        ram_rd_en   = 1'b1;
                        use_ram     = 1'b1;
                        rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                        level_next  = level_reg - 1'b1;
                    end
                end
                i2cm_pkg::W_SS_HCNT:   res.read_data = 32'(ss_hcnt_reg);
                i2cm_pkg::W_SS_LCNT:   res.read_data = 32'(ss_lcnt_reg);
                i2cm_pkg::W_FS_HCNT:   res.read_data = 32'(fs_hcnt_reg);
                i2cm_pkg::W_FS_LCNT:   res.read_data = 32'(fs_lcnt_reg);
                i2cm_pkg::W_INTR_STAT: res.read_data = 32'(raw_reg & mask_reg);
                i2cm_pkg::W_INTR_MASK: res.read_data = 32'(mask_reg);
                i2cm_pkg::W_RAW_STAT:  res.read_data = 32'(raw_reg);
                i2cm_pkg::W_RX_TL:     res.read_data = 32'(rx_tl_reg);
                i2cm_pkg::W_TX_TL:     res.read_data = 32'(tx_tl_reg);
                i2cm_pkg::W_CLR_INTR: begin
                    res.read_data = 32'(raw_reg);
                    raw_mod       = '0;
                end
                i2cm_pkg::W_CLR_RX_UNDER:  raw_mod = raw_mod & ~i2cm_pkg::INT_RX_UNDER;
                i2cm_pkg::W_CLR_RX_OVER:   raw_mod = raw_mod & ~i2cm_pkg::INT_RX_OVER;
                i2cm_pkg::W_CLR_TX_OVER:   raw_mod = raw_mod & ~i2cm_pkg::INT_TX_OVER;
                i2cm_pkg::W_CLR_TX_ABRT:   raw_mod = raw_mod & ~i2cm_pkg::INT_TX_ABRT;
                i2cm_pkg::W_CLR_STOP_DET:  raw_mod = raw_mod & ~i2cm_pkg::INT_STOP_DET;
                i2cm_pkg::W_CLR_START_DET: raw_mod = raw_mod & ~i2cm_pkg::INT_START_DET;
                i2cm_pkg::W_ENABLE:    res.read_data = 32'(enable_reg);
                i2cm_pkg::W_STATUS:    res.read_data = status_word;
                i2cm_pkg::W_RXFLR:     res.read_data = 32'(level_reg);
                i2cm_pkg::W_HOLD_TIME: res.read_data = 32'(hold_time_reg);
                i2cm_pkg::W_DMA_CR:    res.read_data = 32'(dma_cr_reg);
                i2cm_pkg::W_DMA_TDLR:  res.read_data = 32'(dma_tdlr_reg);
                i2cm_pkg::W_DMA_RDLR:  res.read_data = 32'(dma_rdlr_reg);
                i2cm_pkg::W_SPKLEN:    res.read_data = 32'(spklen_reg);
                i2cm_pkg::W_PARAM1:    res.read_data = i2cm_pkg::ID_PARAM1;
                i2cm_pkg::W_VERSION:   res.read_data = i2cm_pkg::ID_VERSION;
                i2cm_pkg::W_TYPE:      res.read_data = i2cm_pkg::ID_TYPE;
                default:               res.read_data = '0;
            endcase
        end

        // Status update on writes and XFER_CMD reads: TX idle set, RX_FULL tracks level above threshold
        raw_upd = raw_mod | i2cm_pkg::INT_TX_IDLE;
        if (CMP_W'(level_next) > CMP_W'(rx_tl_next)) begin
            raw_upd = raw_upd | i2cm_pkg::INT_RX_FULL;
        end else begin
            raw_upd = raw_upd & ~i2cm_pkg::INT_RX_FULL;
        end
        raw_next = do_update ? raw_upd : raw_mod;
        res.irq_pulse = do_update && ((raw_upd & mask_next) != '0);
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            con_reg      <= i2cm_pkg::RST_CON;
            tar_reg      <= i2cm_pkg::RST_TAR;
            sar_reg      <= i2cm_pkg::RST_SAR;
            ss_hcnt_reg  <= i2cm_pkg::RST_SS_HCNT;
            ss_lcnt_reg  <= i2cm_pkg::RST_SS_LCNT;
            fs_hcnt_reg  <= i2cm_pkg::RST_FS_HCNT;
            fs_lcnt_reg  <= i2cm_pkg::RST_FS_LCNT;
            mask_reg     <= '0;
            raw_reg      <= '0;
            rx_tl_reg    <= '0;
            tx_tl_reg    <= '0;
            enable_reg   <= '0;
            hold_time_reg <= i2cm_pkg::RST_HOLD_TIME;
            dma_cr_reg   <= '0;
            dma_tdlr_reg <= '0;
            dma_rdlr_reg <= '0;
            spklen_reg   <= i2cm_pkg::RST_SPKLEN;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            level_reg    <= '0;
        end else if (accept) begin
            con_reg      <= con_next;
            tar_reg      <= tar_next;
            sar_reg      <= sar_next;
            ss_hcnt_reg  <= ss_hcnt_next;
            ss_lcnt_reg  <= ss_lcnt_next;
            fs_hcnt_reg  <= fs_hcnt_next;
            fs_lcnt_reg  <= fs_lcnt_next;
            mask_reg     <= mask_next;
            raw_reg      <= raw_next;
            rx_tl_reg    <= rx_tl_next;
            tx_tl_reg    <= tx_tl_next;
            enable_reg   <= enable_next;
            hold_time_reg <= hold_time_next;
            dma_cr_reg   <= dma_cr_next;
            dma_tdlr_reg <= dma_tdlr_next;
            dma_rdlr_reg <= dma_rdlr_next;
            spklen_reg   <= spklen_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            level_reg    <= level_next;
        end
    end

    // FIFO bookkeeping checks
    `I2CM_ASSERT(a_level_bound, aclk, aresetn, level_reg <= LVL_FULL)
    `I2CM_ASSERT(a_empty_ptrs, aclk, aresetn, (level_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
    `I2CM_ASSERT(a_full_ptrs, aclk, aresetn, (level_reg == LVL_FULL) |-> (wr_ptr_reg == rd_ptr_reg))
    `I2CM_ASSERT(a_no_push_full, aclk, aresetn, (accept && ram_wr_en) |-> !fifo_full)

endmodule

// ===== rtl/i2c_master_register_block_core.sv =====
// Top level of the I2C controller register block with receive FIFO.
//
// Usage:
//   Slave channel (s_*): one register access per beat. s_tuser carries the
//   access kind (0 read, 1 write); s_tdata carries offset, write value,
//   device-present flag and the device's read byte.
//   Master channel (m_*): exactly one result beat per access, in order:
//   read value, interrupt pulse, target address and the bus strobes.
//   A result passes through the middle stage and then the output register
//   before m_tvalid. Throughput: one access per cycle while m_tready does
//   not stall the output, set by the register update and the registered
//   read of the receive FIFO RAM. A pop reads the RAM at the acceptance edge;
//   the byte is merged into the output register when the middle stage moves.
//   Reset (aresetn low, synchronous): all settings return to their defaults,
//   status and FIFO level clear, the pipeline empties. FIFO RAM contents are
//   not cleared; only written entries are ever read.
//   Stall: with m_tready low the output register holds its beat, one more
//   access is taken into the middle stage, then s_tready drops.
`include "i2c_master_register_block_core_defines.svh"

module i2c_master_register_block_core #(
    parameter int RX_DEPTH = i2cm_pkg::RX_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // access channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // func
    input  logic [47:0] s_tdata,   // reg_word[5:0], write_data[37:6],
                                   // device_present[38], device_byte[46:39], zero[47]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // read_data[31:0], irq_pulse[32], target_addr[39:33],
                                   // bus_restart[40], bus_write[41],
                                   // bus_write_byte[49:42], bus_read[50], bus_stop[51],
                                   // zero[55:52]
);

    localparam int PTR_W = $clog2(RX_DEPTH);

    i2cm_pkg::req_t    req;
    i2cm_pkg::result_t res;
    logic              use_ram;
    logic              accept;
    logic              s1_move;

    logic              ram_wr_en;
    logic [PTR_W-1:0]  ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [PTR_W-1:0]  ram_rd_addr;
    logic [7:0]        ram_rd_data;

    logic              s1_valid_reg, s1_valid_next;
    i2cm_pkg::result_t s1_res_reg;
    logic              s1_use_ram_reg;
    logic              out_valid_reg, out_valid_next;
    i2cm_pkg::result_t out_res_reg, out_res_next;

    // Beat unpacking
    assign req.func           = s_tuser;
    assign req.reg_word       = s_tdata[5:0];
    assign req.write_data     = s_tdata[37:6];
    assign req.device_present = s_tdata[38];
    assign req.device_byte    = s_tdata[46:39];

    // Handshake: middle stage drains into the output register
    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    i2cm_regs #(
        .RX_DEPTH(RX_DEPTH)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .req        (req),
        .res        (res),
        .use_ram    (use_ram),
        .ram_wr_en  (ram_wr_en),
        .ram_wr_addr(ram_wr_addr),
        .ram_wr_data(ram_wr_data),
        .ram_rd_en  (ram_rd_en),
        .ram_rd_addr(ram_rd_addr)
    );

    i2cm_ram #(
        .WIDTH(8),
        .DEPTH(RX_DEPTH)
    ) u_rx_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en && accept),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en && accept),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // Next-state for the two pipeline stages
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        // merge the popped byte from the RAM
        out_res_next = s1_res_reg;
        if (s1_use_ram_reg) begin
            out_res_next.read_data = 32'(ram_rd_data);
        end
    end

    // Pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_res_reg     <= res;
            s1_use_ram_reg <= use_ram;
        end
        if (s1_move) begin
            out_res_reg <= out_res_next;
        end
    end

    // Result beat packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_res_reg.bus_stop,
                       out_res_reg.bus_read,
                       out_res_reg.bus_write_byte,
                       out_res_reg.bus_write,
                       out_res_reg.bus_restart,
                       out_res_reg.target_addr,
                       out_res_reg.irq_pulse,
                       out_res_reg.read_data};

    // Pipeline checks
    `I2CM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!out_valid_reg && !s1_valid_reg))
    `I2CM_ASSERT(a_full_backpress, aclk, aresetn, (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
    `I2CM_ASSERT(a_move_fills_out, aclk, aresetn, s1_move |=> out_valid_reg)

endmodule

// ===== tb/tb_i2c_master_register_block_core.sv =====
// Self-checking stream testbench for the I2C controller register block with receive FIFO.
module tb_i2c_master_register_block_core;

    localparam int STALL_LIMIT    = 1000;
    localparam int LONG_HOLD      = 60;
    localparam int TOTAL_ACCESSES = 450;
    localparam int RX_PTR_W       = $clog2(i2cm_pkg::RX_DEPTH_DEF);

    // Register map model plus the queue of results still owed by the block
    class regmap_tracker;
        i2cm_pkg::result_t due_results[$];
        int          mismatches;
        logic [6:0]  con_r;
        logic [9:0]  tar_r;
        logic [9:0]  sar_r;
        logic [15:0] scl_cnt[4];
        logic [11:0] irq_mask;
        logic [11:0] raw_stat;
        logic [7:0]  rx_tl;
        logic [7:0]  tx_tl;
        logic [1:0]  enable_r;
        logic [15:0] hold_time;
        logic [4:0]  dma_r[3];
        logic [7:0]  spklen;
        logic [7:0]  rx_mem[i2cm_pkg::RX_DEPTH_DEF];
        int          rx_wr;
        int          rx_rd;
        int          rx_fill;

        function new();
            mismatches = 0;
            con_r      = i2cm_pkg::RST_CON;
            tar_r      = i2cm_pkg::RST_TAR;
            sar_r      = i2cm_pkg::RST_SAR;
            scl_cnt[0] = i2cm_pkg::RST_SS_HCNT;
            scl_cnt[1] = i2cm_pkg::RST_SS_LCNT;
            scl_cnt[2] = i2cm_pkg::RST_FS_HCNT;
            scl_cnt[3] = i2cm_pkg::RST_FS_LCNT;
            irq_mask   = '0;
            raw_stat   = '0;
            rx_tl      = '0;
            tx_tl      = '0;
            enable_r   = '0;
            hold_time  = i2cm_pkg::RST_HOLD_TIME;
            dma_r[0]   = '0;
            dma_r[1]   = '0;
            dma_r[2]   = '0;
            spklen     = i2cm_pkg::RST_SPKLEN;
            rx_wr      = 0;
            rx_rd      = 0;
            rx_fill    = 0;
        endfunction

        // TX is always idle; RX_FULL tracks the level against the threshold
        function logic refresh_status();
            raw_stat |= i2cm_pkg::INT_TX_IDLE;
            if (rx_fill > rx_tl) raw_stat |= i2cm_pkg::INT_RX_FULL;
            else raw_stat &= ~i2cm_pkg::INT_RX_FULL;
            return (raw_stat & irq_mask) != '0;
        endfunction

        // Apply one accepted beat and queue the result it must produce
        function void note_access(i2cm_pkg::req_t a);
            i2cm_pkg::result_t r;
            logic [31:0]       d;
            r = '0;
            d = a.write_data;
            if (a.func == i2cm_pkg::FUNC_READ) begin
                case (a.reg_word)
                    i2cm_pkg::W_CON:       r.read_data = {25'd0, con_r};
                    i2cm_pkg::W_TAR:       r.read_data = {22'd0, tar_r};
                    i2cm_pkg::W_SAR:       r.read_data = {22'd0, sar_r};
                    i2cm_pkg::W_XFER_CMD: begin
                        if (rx_fill == 0) begin
                            raw_stat |= i2cm_pkg::INT_RX_UNDER;
                        end else begin
                            r.read_data = {24'd0, rx_mem[rx_rd[RX_PTR_W-1:0]]};
                            rx_rd = (rx_rd + 1) % i2cm_pkg::RX_DEPTH_DEF;
                            rx_fill--;
                        end
                        r.irq_pulse = refresh_status();
                    end
                    i2cm_pkg::W_SS_HCNT:   r.read_data = {16'd0, scl_cnt[0]};
                    i2cm_pkg::W_SS_LCNT:   r.read_data = {16'd0, scl_cnt[1]};
                    i2cm_pkg::W_FS_HCNT:   r.read_data = {16'd0, scl_cnt[2]};
                    i2cm_pkg::W_FS_LCNT:   r.read_data = {16'd0, scl_cnt[3]};
                    i2cm_pkg::W_INTR_STAT: r.read_data = {20'd0, raw_stat & irq_mask};
                    i2cm_pkg::W_INTR_MASK: r.read_data = {20'd0, irq_mask};
                    i2cm_pkg::W_RAW_STAT:  r.read_data = {20'd0, raw_stat};
                    i2cm_pkg::W_RX_TL:     r.read_data = {24'd0, rx_tl};
                    i2cm_pkg::W_TX_TL:     r.read_data = {24'd0, tx_tl};
                    i2cm_pkg::W_CLR_INTR: begin
                        r.read_data = {20'd0, raw_stat};
                        raw_stat = '0;
                    end
                    i2cm_pkg::W_CLR_RX_UNDER:  raw_stat &= ~i2cm_pkg::INT_RX_UNDER;
                    i2cm_pkg::W_CLR_RX_OVER:   raw_stat &= ~i2cm_pkg::INT_RX_OVER;
                    i2cm_pkg::W_CLR_TX_OVER:   raw_stat &= ~i2cm_pkg::INT_TX_OVER;
                    i2cm_pkg::W_CLR_TX_ABRT:   raw_stat &= ~i2cm_pkg::INT_TX_ABRT;
                    i2cm_pkg::W_CLR_STOP_DET:  raw_stat &= ~i2cm_pkg::INT_STOP_DET;
                    i2cm_pkg::W_CLR_START_DET: raw_stat &= ~i2cm_pkg::INT_START_DET;
                    i2cm_pkg::W_ENABLE:    r.read_data = {30'd0, enable_r};
                    // bits 1 and 2 fixed high, bit 3 not empty, bit 4 full
                    i2cm_pkg::W_STATUS:    r.read_data = {27'd0,
                                                          rx_fill >= i2cm_pkg::RX_DEPTH_DEF,
                                                          rx_fill > 0, 2'b11, 1'b0};
                    i2cm_pkg::W_RXFLR:     r.read_data = 32'(rx_fill);
                    i2cm_pkg::W_HOLD_TIME: r.read_data = {16'd0, hold_time};
                    i2cm_pkg::W_DMA_CR:    r.read_data = {27'd0, dma_r[0]};
                    i2cm_pkg::W_DMA_TDLR:  r.read_data = {27'd0, dma_r[1]};
                    i2cm_pkg::W_DMA_RDLR:  r.read_data = {27'd0, dma_r[2]};
                    i2cm_pkg::W_SPKLEN:    r.read_data = {24'd0, spklen};
                    i2cm_pkg::W_PARAM1:    r.read_data = i2cm_pkg::ID_PARAM1;
                    i2cm_pkg::W_VERSION:   r.read_data = i2cm_pkg::ID_VERSION;
                    i2cm_pkg::W_TYPE:      r.read_data = i2cm_pkg::ID_TYPE;
                    default:               r.read_data = '0;
                endcase
            end else begin
                case (a.reg_word)
                    i2cm_pkg::W_CON:       con_r = d[6:0];
                    i2cm_pkg::W_TAR:       tar_r = d[9:0];
                    i2cm_pkg::W_SAR:       sar_r = d[9:0];
                    // transfer runs at once toward the current target
                    i2cm_pkg::W_XFER_CMD: begin
                        r.target_addr = tar_r[6:0];
                        r.bus_restart = d[i2cm_pkg::CMD_RESTART_BIT] && a.device_present;
                        if (d[i2cm_pkg::CMD_READ_BIT]) begin
                            r.bus_read = a.device_present;
                            if (rx_fill >= i2cm_pkg::RX_DEPTH_DEF) begin
                                raw_stat |= i2cm_pkg::INT_RX_OVER;
                            end else begin
                                rx_mem[rx_wr[RX_PTR_W-1:0]] =
                                    a.device_present ? a.device_byte
                                                     : i2cm_pkg::NO_DEVICE_BYTE;
                                rx_wr = (rx_wr + 1) % i2cm_pkg::RX_DEPTH_DEF;
                                rx_fill++;
                            end
                        end else if (a.device_present) begin
                            r.bus_write      = 1'b1;
                            r.bus_write_byte = d[7:0];
                        end
                        if (d[i2cm_pkg::CMD_STOP_BIT]) begin
                            raw_stat |= i2cm_pkg::INT_STOP_DET;
                            r.bus_stop = a.device_present;
                        end
                    end
                    i2cm_pkg::W_SS_HCNT:     scl_cnt[0] = d[15:0];
                    i2cm_pkg::W_SS_LCNT:     scl_cnt[1] = d[15:0];
                    i2cm_pkg::W_FS_HCNT:     scl_cnt[2] = d[15:0];
                    i2cm_pkg::W_FS_LCNT:     scl_cnt[3] = d[15:0];
                    i2cm_pkg::W_INTR_MASK:   irq_mask = d[11:0];
                    i2cm_pkg::W_RX_TL:       rx_tl = d[7:0];
                    i2cm_pkg::W_TX_TL:       tx_tl = d[7:0];
                    i2cm_pkg::W_CLR_INTR:    raw_stat = '0;
                    i2cm_pkg::W_CLR_TX_ABRT: raw_stat &= ~i2cm_pkg::INT_TX_ABRT;
                    i2cm_pkg::W_ENABLE:      enable_r = d[1:0];
                    i2cm_pkg::W_HOLD_TIME:   hold_time = d[15:0];
                    i2cm_pkg::W_DMA_CR:      dma_r[0] = {3'd0, d[1:0]};
                    i2cm_pkg::W_DMA_TDLR:    dma_r[1] = d[4:0];
                    i2cm_pkg::W_DMA_RDLR:    dma_r[2] = d[4:0];
                    i2cm_pkg::W_SPKLEN:      spklen = d[7:0];
                    default: ;
                endcase
                r.irq_pulse = refresh_status();
            end
            due_results.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        // Compare a received beat with the oldest owed result
        task check_result(i2cm_pkg::result_t got);
            i2cm_pkg::result_t want;
            if (due_results.size() == 0) begin
                report($sformatf("result beat with nothing owed, data %h", got));
                return;
            end
            want = due_results.pop_front();
            if (got.read_data !== want.read_data)
                report($sformatf("read_data got %h want %h", got.read_data, want.read_data));
            if (got.irq_pulse !== want.irq_pulse)
                report($sformatf("irq_pulse got %b want %b", got.irq_pulse, want.irq_pulse));
            if (got.target_addr !== want.target_addr)
                report($sformatf("target_addr got %h want %h",
                                 got.target_addr, want.target_addr));
            if (got.bus_restart !== want.bus_restart)
                report($sformatf("bus_restart got %b want %b",
                                 got.bus_restart, want.bus_restart));
            if (got.bus_write !== want.bus_write)
                report($sformatf("bus_write got %b want %b", got.bus_write, want.bus_write));
            if (got.bus_write_byte !== want.bus_write_byte)
                report($sformatf("bus_write_byte got %h want %h",
                                 got.bus_write_byte, want.bus_write_byte));
            if (got.bus_read !== want.bus_read)
                report($sformatf("bus_read got %b want %b", got.bus_read, want.bus_read));
            if (got.bus_stop !== want.bus_stop)
                report($sformatf("bus_stop got %b want %b", got.bus_stop, want.bus_stop));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    regmap_tracker tracker;
    logic send_idle_on = 1'b1;
    logic recv_idle_on = 1'b1;
    logic hold_result_sink = 1'b0;
    int   accesses_sent = 0;

    logic [5:0] rw_regs [18] = '{
        i2cm_pkg::W_CON, i2cm_pkg::W_TAR, i2cm_pkg::W_SAR, i2cm_pkg::W_SS_HCNT,
        i2cm_pkg::W_SS_LCNT, i2cm_pkg::W_FS_HCNT, i2cm_pkg::W_FS_LCNT,
        i2cm_pkg::W_INTR_MASK, i2cm_pkg::W_RX_TL, i2cm_pkg::W_TX_TL, i2cm_pkg::W_ENABLE,
        i2cm_pkg::W_HOLD_TIME, i2cm_pkg::W_DMA_CR, i2cm_pkg::W_DMA_TDLR,
        i2cm_pkg::W_DMA_RDLR, i2cm_pkg::W_SPKLEN, i2cm_pkg::W_CLR_INTR,
        i2cm_pkg::W_CLR_TX_ABRT};
    logic [5:0] status_regs [14] = '{
        i2cm_pkg::W_INTR_STAT, i2cm_pkg::W_RAW_STAT, i2cm_pkg::W_CLR_INTR,
        i2cm_pkg::W_CLR_RX_UNDER, i2cm_pkg::W_CLR_RX_OVER, i2cm_pkg::W_CLR_TX_OVER,
        i2cm_pkg::W_CLR_TX_ABRT, i2cm_pkg::W_CLR_STOP_DET, i2cm_pkg::W_CLR_START_DET,
        i2cm_pkg::W_CLR_RESTART, i2cm_pkg::W_STATUS, i2cm_pkg::W_TXFLR,
        i2cm_pkg::W_RXFLR, i2cm_pkg::W_ABRT_SRC};

    i2c_master_register_block_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Write values biased toward extremes and small thresholds
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    // Offer one access beat; handshake is sampled at the falling edge
    task automatic send_access(input logic func, input logic [5:0] word,
                               input logic [31:0] data, input logic present,
                               input logic [7:0] dbyte);
        i2cm_pkg::req_t acc;
        int             gap;
        logic           taken;
        acc.func           = func;
        acc.reg_word       = word;
        acc.write_data     = data;
        acc.device_present = present;
        acc.device_byte    = dbyte;
        gap = send_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= acc.func;
        s_tdata  <= {1'b0, acc.device_byte, acc.device_present, acc.write_data,
                     acc.reg_word};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        tracker.note_access(acc);
        accesses_sent++;
    endtask

    // Sender goes quiet until every owed result is back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.due_results.size() != 0) @(posedge aclk);
    endtask

    // Result sink with random back-pressure and an occasional long hold
    initial begin : result_sink
        int                gap;
        logic              got;
        i2cm_pkg::result_t res;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_result_sink) begin
                gap = LONG_HOLD;
                hold_result_sink = 1'b0;
            end else begin
                gap = recv_idle_on ? $urandom_range(0, 5) : 0;
            end
            if ($urandom_range(0, 29) == 0) recv_idle_on = !recv_idle_on;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                got = m_tvalid;
                res.read_data      = m_tdata[31:0];
                res.irq_pulse      = m_tdata[32];
                res.target_addr    = m_tdata[39:33];
                res.bus_restart    = m_tdata[40];
                res.bus_write      = m_tdata[41];
                res.bus_write_byte = m_tdata[49:42];
                res.bus_read       = m_tdata[50];
                res.bus_stop       = m_tdata[51];
                @(posedge aclk);
            end while (!got);
            tracker.check_result(res);
        end
    end

    // Ends the run when no beat moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("** i2c_master_register_block_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int          n;
        logic [31:0] d;
        tracker = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identification words, reset values, pop from an empty FIFO
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_TYPE, '1, 1'b1, 8'hFF);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_VERSION, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_PARAM1, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_CON, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_STATUS, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_XFER_CMD, '0, 1'b1, 8'h5A);
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_INTR_MASK, '1, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_RX_TL, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_TAR, '1, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_TAR, '0, 1'b0, 8'h00);
        // write with restart and stop, read with every command bit, absent device
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_XFER_CMD, 32'h0000_06FF, 1'b1, 8'h00);
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_XFER_CMD, '1, 1'b1, 8'hFF);
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_XFER_CMD, 32'h0000_0700, 1'b0, 8'h3C);
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_XFER_CMD, '0, 1'b1, 8'h00);
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_XFER_CMD, 32'h0000_0600, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_RXFLR, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_STATUS, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_RAW_STAT, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_INTR_STAT, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_CLR_STOP_DET, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_CLR_INTR, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_CLR_TX_ABRT, '1, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_XFER_CMD, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_XFER_CMD, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_CLR_INTR, '0, 1'b0, 8'h00);
        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_INTR_MASK, '0, 1'b0, 8'h00);

        // sender pause, then a long sink hold while a fill burst overflows
        wait_drain();
        hold_result_sink = 1'b1;
        send_idle_on = 1'b0;
        repeat (20) begin
            d = $urandom;
            d[i2cm_pkg::CMD_READ_BIT] = 1'b1;
            send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_XFER_CMD, d,
                        1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end

        // random mix of transfer bursts, drains and register traffic
        while (accesses_sent < TOTAL_ACCESSES) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 29) == 0) hold_result_sink = 1'b1;
            if ($urandom_range(0, 39) == 0) wait_drain();
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(1, 20);
                    repeat (n) begin
                        d = $urandom;
                        d[i2cm_pkg::CMD_READ_BIT] = ($urandom_range(0, 4) != 0);
                        send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_XFER_CMD, d,
                                    1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                    end
                end
                3, 4: begin
                    n = $urandom_range(1, 20);
                    repeat (n)
                        send_access(i2cm_pkg::FUNC_READ, i2cm_pkg::W_XFER_CMD, $urandom,
                                    1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
                5: send_access(i2cm_pkg::FUNC_READ, status_regs[4'($urandom_range(0, 13))],
                               $urandom, 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, 255)));
                6: send_access(i2cm_pkg::FUNC_WRITE, rw_regs[5'($urandom_range(0, 17))],
                               pick_value(), 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, 255)));
                7: send_access(i2cm_pkg::FUNC_READ, rw_regs[5'($urandom_range(0, 17))],
                               $urandom, 1'($urandom_range(0, 1)),
                               8'($urandom_range(0, 255)));
                8: send_access(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), $urandom,
                               1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                default: send_access(i2cm_pkg::FUNC_WRITE, i2cm_pkg::W_XFER_CMD, pick_value(),
                                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            endcase
        end

        wait_drain();
        repeat (16) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
            $display("** i2c_master_register_block_core: PASSED **");
        end else begin
            $display("** i2c_master_register_block_core: FAILED **");
        end
        $finish;
    end

endmodule
